// ----- hw/rtl/wheel_speed_pi_controller_assert.svh -----
// Assertion macros for the wheel speed PI controller.
// Included by the top level; expects clk and arst_n in scope.
`ifndef WHEEL_SPEED_PI_CONTROLLER_ASSERT_SVH
`define WHEEL_SPEED_PI_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSPC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wspc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WSPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wspc: next-cycle check failed");

`endif

// ----- hw/rtl/wspc_pkg.sv -----
// Shared constants, register indexes and control structs of the wheel speed
// PI controller. Used by wspc_window, wspc_loop and the top level.
package wspc_pkg;

	// Default length of the error averaging window.
	localparam int WINDOW_LEN_DEF = 10;

	// Datapath widths.
	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 24;
	localparam int STEP_W   = 8;
	localparam int SMOOTH_W = 33;  // Q16.16 filtered error, bounded by 2^31.
	localparam int INTEG_W  = 32;  // Q16.16 integral, clamped well inside.
	localparam int ACC_W    = 34;
	localparam int DRIVE_W  = 32;

	// Low-pass coefficients 0.8 and 0.2 with 16 fraction bits.
	localparam int LP_SHIFT = 16;
	localparam logic signed [16:0] LP_KEEP = 17'sd52429;
	localparam logic signed [14:0] LP_TAKE = 15'sd13107;

	// Integral clamp of 10000.0 in Q16.16, and the drive scaling shift.
	localparam logic signed [ACC_W-1:0] INTEG_LIMIT = 34'sd655360000;
	localparam int DRIVE_SHIFT = 28;

	// Tilt cutoff of 40 degrees in centidegrees.
	localparam logic signed [SAMPLE_W-1:0] TILT_LIMIT = 16'sd4000;

	// Configuration register indexes.
	localparam logic [1:0] REG_SPEED_GAIN    = 2'd0;
	localparam logic [1:0] REG_POSITION_GAIN = 2'd1;
	localparam logic [1:0] REG_SPEED_STEP    = 2'd2;

	// Sequencer strobes for the window unit.
	typedef struct packed {
		logic rd_en;    // read the slot about to be replaced
		logic update;   // replace the sample and update the running sum
		logic divide;   // start the divide by the window length
		logic mean_en;  // register the signed mean
	} wspc_win_ctrl_t;

	// Sequencer strobes and item flags for the control loop.
	typedef struct packed {
		logic keep;       // form smoothed * 0.8
		logic take;       // form mean * 0.2
		logic integrate;  // update smoothed error and integral
		logic multiply;   // form both gain products
		logic finish;     // drive is taken; apply the late integral clear
		logic clr_pre;    // clear integral before clamping
		logic clr_post;   // clear integral after the drive is formed
	} wspc_loop_ctrl_t;

endpackage

// ----- hw/rtl/wspc_window.sv -----
// Moving-average window of the speed error: sample memory, running sum and
// divide by the window length. Depends on wspc_pkg.
module wspc_window #(
	parameter int WINDOW_LEN = wspc_pkg::WINDOW_LEN_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  wspc_pkg::wspc_win_ctrl_t              ctrl,
	input  logic signed [wspc_pkg::SAMPLE_W-1:0]  sample,
	output logic signed [wspc_pkg::SAMPLE_W-1:0]  mean
);

	localparam int L_W      = $clog2(WINDOW_LEN);
	localparam int SLOT_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int SUM_W    = wspc_pkg::SAMPLE_W + L_W;
	localparam int RECIP_W  = SUM_W + 1;
	localparam int RECIP_SH = SUM_W + L_W;
	localparam int PROD_W   = SUM_W + RECIP_W;
	localparam int QUOT_W   = PROD_W - RECIP_SH;
	localparam longint unsigned RECIP_FULL =
		((64'd1 << RECIP_SH) + WINDOW_LEN - 1) / WINDOW_LEN;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

	logic signed [wspc_pkg::SAMPLE_W-1:0] mem [WINDOW_LEN];
	logic signed [wspc_pkg::SAMPLE_W-1:0] rd_q;
	logic [WINDOW_LEN-1:0]                valid_q;
	logic [SLOT_W-1:0]                    slot_q;
	logic signed [SUM_W-1:0]              sum_q;
	logic [PROD_W-1:0]                    prod_q;
	logic                                 neg_q;
	logic signed [wspc_pkg::SAMPLE_W-1:0] mean_q;

	logic signed [wspc_pkg::SAMPLE_W-1:0] old_sample;
	logic [SUM_W-1:0]                     mag;
	logic [QUOT_W-1:0]                    quot;
	logic [QUOT_W-1:0]                    quot_signed;

	// Sample memory: one read and one write port, registered read data.
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_q <= mem[slot_q];
		end
		if (ctrl.update) begin
			mem[slot_q] <= sample;
		end
	end

	// A slot never written since reset holds a zero sample.
	assign old_sample = valid_q[slot_q] ? rd_q : '0;

	// Magnitude of the sum for the truncating divide.
	assign mag = sum_q[SUM_W-1] ? unsigned'(SUM_W'(-sum_q)) : unsigned'(sum_q);

	// Quotient from the reciprocal product, with the sign restored.
	assign quot        = prod_q[PROD_W-1:RECIP_SH];
	assign quot_signed = neg_q ? (~quot + 1'b1) : quot;

	// Valid bits, slot pointer, running sum and the divide stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			slot_q  <= '0;
			sum_q   <= '0;
			prod_q  <= '0;
			neg_q   <= 1'b0;
			mean_q  <= '0;
		end else begin
			if (ctrl.update) begin
				valid_q[slot_q] <= 1'b1;
				sum_q <= sum_q - SUM_W'(old_sample) + SUM_W'(sample);
				if (slot_q == SLOT_W'(WINDOW_LEN - 1)) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
			if (ctrl.divide) begin
				prod_q <= PROD_W'(mag) * PROD_W'(RECIP);
				neg_q  <= sum_q[SUM_W-1];
			end
			if (ctrl.mean_en) begin
				mean_q <= signed'(quot_signed[wspc_pkg::SAMPLE_W-1:0]);
			end
		end
	end

	assign mean = mean_q;

endmodule

// ----- hw/rtl/wspc_loop.sv -----
// Low-pass filter, clamped integrator and drive computation of the speed
// loop. Depends on wspc_pkg.
module wspc_loop (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  wspc_pkg::wspc_loop_ctrl_t             ctrl,
	input  logic signed [wspc_pkg::SAMPLE_W-1:0]  mean,
	input  logic signed [wspc_pkg::GAIN_W-1:0]    speed_gain,
	input  logic signed [wspc_pkg::GAIN_W-1:0]    position_gain,
	output logic signed [wspc_pkg::DRIVE_W-1:0]   drive,
	output logic signed [wspc_pkg::INTEG_W-1:0]   integral
);

	localparam int SW       = wspc_pkg::SMOOTH_W;
	localparam int IW       = wspc_pkg::INTEG_W;
	localparam int AW       = wspc_pkg::ACC_W;
	localparam int KEEP_W   = SW + 17;
	localparam int TAKE_W   = wspc_pkg::SAMPLE_W + 15;
	localparam int P1_W     = SW + wspc_pkg::GAIN_W;
	localparam int P2_W     = IW + wspc_pkg::GAIN_W;
	localparam int TOT_W    = P1_W + 1;
	localparam int SH       = wspc_pkg::LP_SHIFT;
	localparam int DSH      = wspc_pkg::DRIVE_SHIFT;
	localparam int DRIVE_W  = wspc_pkg::DRIVE_W;

	logic signed [SW-1:0]     smooth_q;
	logic signed [IW-1:0]     integ_q;
	logic signed [KEEP_W-1:0] keep_q;
	logic signed [TAKE_W-1:0] take_q;
	logic signed [P1_W-1:0]   p1_q;
	logic signed [P2_W-1:0]   p2_q;

	logic signed [KEEP_W-1:0] keep_adj;
	logic signed [SW-1:0]     smooth_new;
	logic signed [AW-1:0]     acc;
	logic signed [AW-1:0]     acc_clamped;
	logic signed [TOT_W-1:0]  total;
	logic signed [TOT_W-1:0]  total_adj;

	// smoothed * 0.8, truncated toward zero: bias negative values first.
	assign keep_adj   = keep_q + KEEP_W'({{SH{keep_q[KEEP_W-1]}}});
	assign smooth_new = keep_adj[SH+SW-1:SH] + SW'(take_q);

	// Integrate, clear on remote activity, then clamp to +-10000.0.
	always_comb begin
		acc = AW'(integ_q) + AW'(smooth_new);
		if (ctrl.clr_pre) begin
			acc = '0;
		end
		acc_clamped = acc;
		if (acc > wspc_pkg::INTEG_LIMIT) begin
			acc_clamped = wspc_pkg::INTEG_LIMIT;
		end else if (acc < -wspc_pkg::INTEG_LIMIT) begin
			acc_clamped = -wspc_pkg::INTEG_LIMIT;
		end
	end

	// Drive: sum of products scaled down, truncated toward zero. With the
	// operand ranges bounded the quotient always lies inside 32 bits.
	assign total     = TOT_W'(p1_q) + TOT_W'(p2_q);
	assign total_adj = total + TOT_W'({{DSH{total[TOT_W-1]}}});
	assign drive     = DRIVE_W'(signed'(total_adj[TOT_W-1:DSH]));

	// Filter, integrator and product registers, stepped by the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= '0;
			integ_q  <= '0;
			keep_q   <= '0;
			take_q   <= '0;
			p1_q     <= '0;
			p2_q     <= '0;
		end else begin
			if (ctrl.keep) begin
				keep_q <= KEEP_W'(smooth_q) * KEEP_W'(wspc_pkg::LP_KEEP);
			end
			if (ctrl.take) begin
				take_q <= TAKE_W'(mean) * TAKE_W'(wspc_pkg::LP_TAKE);
			end
			if (ctrl.integrate) begin
				smooth_q <= smooth_new;
				integ_q  <= IW'(acc_clamped);
			end
			if (ctrl.multiply) begin
				p1_q <= P1_W'(smooth_q) * P1_W'(speed_gain);
				p2_q <= P2_W'(integ_q) * P2_W'(position_gain);
			end
			if (ctrl.finish && ctrl.clr_post) begin
				integ_q <= '0;
			end
		end
	end

	assign integral = integ_q;

endmodule

// ----- hw/rtl/wheel_speed_pi_controller.sv -----
// Top level of the wheel speed PI controller: stream ports, APB register
// port, item sequencer and output register. Depends on wspc_pkg,
// wspc_window, wspc_loop and wheel_speed_pi_controller_assert.svh.

// Each item passes through the cycle in which it is accepted, which also
// reads the window slot it replaces, and seven sequencer steps (window
// update, reciprocal multiply, mean, low-pass multiply, integrate, gain
// multiply, drive). The steps follow from that chain of registered
// multiplies and the registered read data of the window memory. The
// input takes a new item as soon as the drive is loaded into the output
// register, even while that result still waits; the drive step holds only
// if the previous result has not been taken yet. Window entries carry
// valid bits that reset clears, so no clearing pass is needed after reset.
`include "wheel_speed_pi_controller_assert.svh"

module wheel_speed_pi_controller #(
	parameter int WINDOW_LEN = wspc_pkg::WINDOW_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input item, from bit 0: left_count[15:0], right_count[15:0],
	// pitch_centideg[15:0], go_forward, go_back, go_left, go_right,
	// braking, following, stop_request, one zero pad bit.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,
	// Result item, from bit 0: drive[31:0], brake_done, seven zero pad bits.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SW = wspc_pkg::SAMPLE_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_DIV,
		S_MEAN,
		S_FILT,
		S_INTEG,
		S_MULT,
		S_DRIVE
	} state_t;

	state_t state_q;

	logic signed [wspc_pkg::GAIN_W-1:0] speed_gain_q;
	logic signed [wspc_pkg::GAIN_W-1:0] position_gain_q;
	logic [wspc_pkg::STEP_W-1:0]        speed_step_q;

	logic signed [SW-1:0] sample_q;
	logic                 done_q;
	logic                 clr_pre_q;
	logic                 clr_post_q;

	// Input fields.
	logic signed [SW-1:0] left_count;
	logic signed [SW-1:0] right_count;
	logic signed [SW-1:0] pitch_centideg;
	logic go_forward, go_back, go_left, go_right, braking, following, stop_request;

	assign left_count     = signed'(s_tdata[15:0]);
	assign right_count    = signed'(s_tdata[31:16]);
	assign pitch_centideg = signed'(s_tdata[47:32]);
	assign go_forward     = s_tdata[48];
	assign go_back        = s_tdata[49];
	assign go_left        = s_tdata[50];
	assign go_right       = s_tdata[51];
	assign braking        = s_tdata[52];
	assign following      = s_tdata[53];
	assign stop_request   = s_tdata[54];

	logic s_accept;
	logic drive_load;

	assign s_tready   = (state_q == S_IDLE);
	assign s_accept   = s_tvalid && s_tready;
	assign drive_load = (state_q == S_DRIVE) && (!m_tvalid || m_tready);

	// Speed target, brake completion and the wrapped error sample.
	logic signed [10:0] step4;
	logic signed [10:0] target;
	logic               done;
	logic signed [17:0] err;

	assign step4 = signed'({1'b0, speed_step_q, 2'b00});

	always_comb begin
		target = '0;
		done   = 1'b0;
		priority if (go_forward) begin
			target = step4;
		end else if (go_back) begin
			target = -step4;
		end else if (braking) begin
			priority if (left_count > 16'sd1) begin
				target = -step4;
			end else if (left_count < -16'sd1) begin
				target = step4;
			end else begin
				done = (right_count >= -16'sd2);
			end
		end else begin
			target = '0;
		end
	end

	assign err = 18'(left_count) + 18'(right_count) - 18'(target);

	// Configuration writes.
	logic [1:0] reg_index;
	logic       cfg_write;

	assign reg_index = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_gain_q    <= '0;
			position_gain_q <= '0;
			speed_step_q    <= '0;
		end else if (cfg_write) begin
			unique case (reg_index)
				wspc_pkg::REG_SPEED_GAIN: begin
					speed_gain_q <= signed'(pwdata[wspc_pkg::GAIN_W-1:0]);
				end
				wspc_pkg::REG_POSITION_GAIN: begin
					position_gain_q <= signed'(pwdata[wspc_pkg::GAIN_W-1:0]);
				end
				wspc_pkg::REG_SPEED_STEP: begin
					speed_step_q <= pwdata[wspc_pkg::STEP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Register readback.
	always_comb begin
		unique case (reg_index)
			wspc_pkg::REG_SPEED_GAIN:    prdata = 32'(unsigned'(speed_gain_q));
			wspc_pkg::REG_POSITION_GAIN: prdata = 32'(unsigned'(position_gain_q));
			wspc_pkg::REG_SPEED_STEP:    prdata = 32'(speed_step_q);
			default:                     prdata = '0;
		endcase
	end

	// Sequencer strobes for the two units.
	wspc_pkg::wspc_win_ctrl_t  win_ctrl;
	wspc_pkg::wspc_loop_ctrl_t loop_ctrl;

	always_comb begin
		win_ctrl.rd_en   = s_accept;
		win_ctrl.update  = (state_q == S_READ);
		win_ctrl.divide  = (state_q == S_DIV);
		win_ctrl.mean_en = (state_q == S_MEAN);

		loop_ctrl.keep      = s_accept;
		loop_ctrl.take      = (state_q == S_FILT);
		loop_ctrl.integrate = (state_q == S_INTEG);
		loop_ctrl.multiply  = (state_q == S_MULT);
		loop_ctrl.finish    = drive_load;
		loop_ctrl.clr_pre   = clr_pre_q;
		loop_ctrl.clr_post  = clr_post_q;
	end

	logic signed [SW-1:0]                mean;
	logic signed [wspc_pkg::DRIVE_W-1:0] drive;
	logic signed [wspc_pkg::INTEG_W-1:0] integral;

	wspc_window #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (win_ctrl),
		.sample (sample_q),
		.mean   (mean)
	);

	wspc_loop u_loop (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (loop_ctrl),
		.mean          (mean),
		.speed_gain    (speed_gain_q),
		.position_gain (position_gain_q),
		.drive         (drive),
		.integral      (integral)
	);

	// Sequencer state, captured item flags and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			sample_q   <= '0;
			done_q     <= 1'b0;
			clr_pre_q  <= 1'b0;
			clr_post_q <= 1'b0;
			m_tvalid   <= 1'b0;
			m_tdata    <= '0;
		end else begin
			// A taken result clears the output unless a new one replaces it.
			if (m_tvalid && m_tready && !drive_load) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						sample_q   <= signed'(err[SW-1:0]);
						done_q     <= done;
						clr_pre_q  <= go_forward || go_back || go_left || go_right ||
							(braking && !done) || following;
						clr_post_q <= (pitch_centideg > wspc_pkg::TILT_LIMIT) ||
							(pitch_centideg < -wspc_pkg::TILT_LIMIT) || stop_request;
						state_q    <= S_READ;
					end
				end
				S_READ:  state_q <= S_DIV;
				S_DIV:   state_q <= S_MEAN;
				S_MEAN:  state_q <= S_FILT;
				S_FILT:  state_q <= S_INTEG;
				S_INTEG: state_q <= S_MULT;
				S_MULT:  state_q <= S_DRIVE;
				S_DRIVE: begin
					if (drive_load) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {7'b0, done_q, unsigned'(drive)};
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The integral never leaves its clamp range.
	`WSPC_ASSERT_IMP(a_integ_clamped, 1'b1,
		(34'(integral) <= wspc_pkg::INTEG_LIMIT) && (34'(integral) >= -wspc_pkg::INTEG_LIMIT))
	// A result appears only out of the drive step.
	`WSPC_ASSERT_IMP(a_result_from_drive, $rose(m_tvalid), $past(state_q == S_DRIVE))
	// An accepted item blocks the input until its result is formed.
	`WSPC_ASSERT_NEXT(a_one_item_in_flight, s_tvalid && s_tready, !s_tready)

endmodule
